@@ hdl/stt_pkg.sv @@
// shared types and constants for the sleep timer table
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

   // operation codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_ADDED    = 3'd0;
   localparam logic [2:0] KIND_FULL     = 3'd1;
   localparam logic [2:0] KIND_ZERO     = 3'd2;
   localparam logic [2:0] KIND_REMOVED  = 3'd3;
   localparam logic [2:0] KIND_NOTFOUND = 3'd4;
   localparam logic [2:0] KIND_WAKE     = 3'd5;

   // time conversion constants
   localparam logic [9:0]  MS_PER_SEC = 10'd1000;
   localparam logic [19:0] NS_PER_MS  = 20'd1000000;
   localparam logic [19:0] NS_ROUND   = 20'd999999;

   // reciprocal multipliers: ceil(2^38 / 1000) and ceil(2^50 / 1000000)
   localparam logic [30:0] RECIP_MS   = 31'd274877907;
   localparam logic [30:0] RECIP_NS   = 31'd1125899907;
   localparam int          Q_MS_LSB   = 38;
   localparam int          Q_NS_LSB   = 50;

   // at most this many wake words per tick
   localparam int MAX_RESULTS = 8;

   // steps the reciprocal divide pipeline needs for quotient and remainder
   localparam int DIV_STEPS = 4;

   // register file
   localparam int         CSR_ADDR_W        = 3;
   localparam logic       CSR_TICK_PERIOD   = 1'b0;
   localparam logic [9:0] TICK_PERIOD_RESET = 10'd10;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  task_id;
      logic [22:0] sleep_seconds;
      logic [29:0] sleep_nanoseconds;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [7:0]  result_task;
      logic [31:0] remaining_ms;
      logic [22:0] remaining_sec;
      logic [29:0] remaining_nsec;
      logic        last;
   } rsp_word_type;

   // one row of the slot memory
   typedef struct packed {
      logic [7:0]  task_id;
      logic [31:0] target_ms;
      logic [31:0] elapsed_ms;
   } slot_entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       div_load_ns;
      logic       div_load_ms;
      logic       div_step;
      logic       write_add;
      logic       write_tick;
      logic       clear_valid;
      logic       pend_load;
      logic       emit;
      logic [2:0] emit_kind;
      logic       emit_pend;
      logic       emit_last;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       zero_req;
      logic       slot_valid;
      logic       task_match;
      logic       due;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/stt_ram.sv @@
// generic single-clock ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module stt_ram #(
   parameter int DATA_W = 72,
   parameter int DEPTH  = 8
) (
   input  wire                                   clock,
   input  wire                                   wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [DATA_W-1:0]                     wr_data,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                     rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/stt_ctrl.sv @@
// sequencer for add, remove and tick operations
`timescale 1ns / 1ps
`default_nettype none

module stt_ctrl #(
   parameter int SLOT_COUNT = 8
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          start,
   output logic                                         busy,
   input  wire  stt_pkg::dp_status_type                 status,
   output stt_pkg::ctrl_cmd_type                        cmd,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] slot
);

   import stt_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int WAKE_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_DIV,
      ST_ADD_SCAN,
      ST_RM_RD,
      ST_RM_CHK,
      ST_RM_DIV,
      ST_RM_OUT,
      ST_TK_RD,
      ST_TK_CHK,
      ST_TK_END
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WAKE_W-1:0]  wake_ff, wake_in;
   logic               pend_ff, pend_in;
   logic               last_slot;
   logic               last_step;

   assign last_slot = (slot_ff == SLOT_W'(SLOT_COUNT - 1));
   assign last_step = (step_ff == STEP_W'(DIV_STEPS - 1));

   // next state and commands
   always_comb begin
      state_in = state_ff;
      slot_in  = slot_ff;
      step_in  = step_ff;
      wake_in  = wake_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            slot_in = '0;
            step_in = '0;
            wake_in = '0;
            pend_in = 1'b0;
            case (status.opcode)
               OP_ADD: begin
                  if (status.zero_req) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_ZERO;
                     cmd.emit_last = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     cmd.div_load_ns = 1'b1;
                     state_in        = ST_ADD_DIV;
                  end
               end
               OP_REMOVE: state_in = ST_RM_RD;
               OP_TICK:   state_in = ST_TK_RD;
               default:   state_in = ST_IDLE;
            endcase
         end
         // nanoseconds to rounded-up milliseconds
         ST_ADD_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_ADD_SCAN;
            end
         end
         // lowest free slot
         ST_ADD_SCAN: begin
            if (!status.slot_valid) begin
               cmd.write_add = 1'b1;
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_ADDED;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else if (last_slot) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_FULL;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         // lowest valid slot holding the task
         ST_RM_RD: begin
            if (status.slot_valid) begin
               state_in = ST_RM_CHK;
            end else if (last_slot) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_NOTFOUND;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_RM_CHK: begin
            if (status.task_match) begin
               cmd.clear_valid = 1'b1;
               cmd.div_load_ms = 1'b1;
               state_in        = ST_RM_DIV;
            end else if (last_slot) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_NOTFOUND;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_RM_RD;
            end
         end
         // remaining ms split into seconds and remainder
         ST_RM_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_RM_OUT;
            end
         end
         ST_RM_OUT: begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_REMOVED;
            cmd.emit_last = 1'b1;
            state_in      = ST_IDLE;
         end
         // advance each valid slot
         ST_TK_RD: begin
            if (status.slot_valid) begin
               state_in = ST_TK_CHK;
            end else if (last_slot) begin
               state_in = ST_TK_END;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         // a due slot under the wake cap becomes pending, the previous pending wake goes out
         ST_TK_CHK: begin
            cmd.write_tick = 1'b1;
            if (status.due && (wake_ff != WAKE_W'(MAX_RESULTS))) begin
               wake_in       = wake_ff + 1'b1;
               cmd.pend_load = 1'b1;
               pend_in       = 1'b1;
               if (pend_ff) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_WAKE;
                  cmd.emit_pend = 1'b1;
               end
            end
            if (last_slot) begin
               state_in = ST_TK_END;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = ST_TK_RD;
            end
         end
         // final wake carries the last flag
         ST_TK_END: begin
            if (pend_ff) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_WAKE;
               cmd.emit_pend = 1'b1;
               cmd.emit_last = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff  <= '0;
         step_ff  <= '0;
         wake_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         step_ff  <= step_in;
         wake_ff  <= wake_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign slot = slot_ff;

endmodule

`default_nettype wire

@@ hdl/stt_datapath.sv @@
// slot storage, divider, time arithmetic and result register
`timescale 1ns / 1ps
`default_nettype none

module stt_datapath #(
   parameter int SLOT_COUNT = 8
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire  stt_pkg::ctrl_cmd_type                  cmd,
   input  wire  [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] slot,
   input  wire  stt_pkg::req_word_type                  req_word,
   input  wire  [9:0]                                   tick_period,
   output stt_pkg::dp_status_type                       status,
   output logic                                         rsp_valid,
   output stt_pkg::rsp_word_type                        rsp_word
);

   import stt_pkg::*;

   localparam int ENTRY_W = $bits(slot_entry_type);

   req_word_type           req_ff;
   logic [SLOT_COUNT-1:0]  valid_ff;
   logic [32:0]            prod_ff;
   logic [31:0]            div_dvd_ff;
   logic                   div_ms_ff;
   logic [62:0]            recip_ff;
   logic [31:0]            div_q_ff;
   logic [31:0]            back_ff;
   logic [9:0]             div_r_ff;
   logic [31:0]            rem_ms_ff;
   logic [7:0]             pend_task_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;

   slot_entry_type         rd_entry;
   slot_entry_type         wr_entry;
   logic                   ram_we;
   logic [33:0]            target_sum;
   logic [31:0]            target_sat;
   logic [32:0]            elapsed_sum;
   logic [31:0]            elapsed_sat;
   logic [31:0]            rem_ms;
   logic [30:0]            recip_mult;
   logic [62:0]            recip_prod;
   logic [32:0]            back_prod;
   logic [31:0]            rem_diff;
   logic [29:0]            nsec_prod;

   // slot rows
   stt_ram #(
      .DATA_W (ENTRY_W),
      .DEPTH  (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot),
      .wr_data (wr_entry),
      .rd_addr (slot),
      .rd_data (rd_entry)
   );

   // add target: seconds in ms plus rounded ms, saturated
   assign target_sum = 34'(prod_ff) + 34'(div_q_ff);
   assign target_sat = (target_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : target_sum[31:0];

   // tick: saturating elapsed advance
   assign elapsed_sum = 33'(rd_entry.elapsed_ms) + 33'(tick_period);
   assign elapsed_sat = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];

   // remove: remaining time clamped at zero
   assign rem_ms = (rd_entry.target_ms > rd_entry.elapsed_ms)
                 ? (rd_entry.target_ms - rd_entry.elapsed_ms) : 32'd0;

   // write data for the slot memory
   always_comb begin
      wr_entry = rd_entry;
      if (cmd.write_add) begin
         wr_entry.task_id    = req_ff.task_id;
         wr_entry.target_ms  = target_sat;
         wr_entry.elapsed_ms = 32'd0;
      end else begin
         wr_entry.elapsed_ms = elapsed_sat;
      end
   end

   assign ram_we = cmd.write_add | cmd.write_tick;

   // reciprocal divide: product, quotient, quotient times 1000, remainder
   assign recip_mult = div_ms_ff ? RECIP_MS : RECIP_NS;
   assign recip_prod = 63'(div_dvd_ff) * 63'(recip_mult);
   assign back_prod  = 33'(div_q_ff[22:0]) * 33'(MS_PER_SEC);
   assign rem_diff   = div_dvd_ff - back_ff;

   assign nsec_prod = 30'(div_r_ff) * 30'(NS_PER_MS);

   // status to the controller
   always_comb begin
      status.opcode     = req_ff.opcode;
      status.zero_req   = (req_ff.sleep_seconds == 23'd0) &&
                          (req_ff.sleep_nanoseconds == 30'd0);
      status.slot_valid = valid_ff[slot];
      status.task_match = (rd_entry.task_id == req_ff.task_id);
      status.due        = (elapsed_sat >= rd_entry.target_ms);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_add) begin
         valid_ff[slot] <= 1'b1;
      end else if (cmd.clear_valid) begin
         valid_ff[slot] <= 1'b0;
      end
   end

   // request capture, product, divider and pending wake
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      prod_ff <= 33'(req_ff.sleep_seconds) * 33'(MS_PER_SEC);
      if (cmd.div_load_ns) begin
         div_dvd_ff <= 32'(req_ff.sleep_nanoseconds) + 32'(NS_ROUND);
         div_ms_ff  <= 1'b0;
      end else if (cmd.div_load_ms) begin
         div_dvd_ff <= rem_ms;
         rem_ms_ff  <= rem_ms;
         div_ms_ff  <= 1'b1;
      end
      if (cmd.div_step) begin
         recip_ff <= recip_prod;
         div_q_ff <= div_ms_ff ? 32'(recip_ff[62:Q_MS_LSB]) : 32'(recip_ff[62:Q_NS_LSB]);
         back_ff  <= back_prod[31:0];
         div_r_ff <= rem_diff[9:0];
      end
      if (cmd.pend_load) begin
         pend_task_ff <= rd_entry.task_id;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_word_ff.result_kind <= cmd.emit_kind;
         rsp_word_ff.result_task <= cmd.emit_pend ? pend_task_ff : req_ff.task_id;
         rsp_word_ff.last        <= cmd.emit_last;
         if (cmd.emit_kind == KIND_REMOVED) begin
            rsp_word_ff.remaining_ms   <= rem_ms_ff;
            rsp_word_ff.remaining_sec  <= div_q_ff[22:0];
            rsp_word_ff.remaining_nsec <= nsec_prod;
         end else begin
            rsp_word_ff.remaining_ms   <= '0;
            rsp_word_ff.remaining_sec  <= '0;
            rsp_word_ff.remaining_nsec <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

@@ hdl/sleep_timer_table.sv @@
// add divides, then scans to the first free slot; remove scans for the task, then divides;
// tick reads every slot and checks each used one, then emits any final wake word
// one word at a time: start is taken only while busy is low, results leave as strobes
// the slot scan and the reciprocal divide set how long each operation takes
// reset is synchronous, clears all slots and sets the tick period to 10 ms
`timescale 1ns / 1ps
`default_nettype none

module sleep_timer_table #(
   parameter int SLOT_COUNT = 8
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire  stt_pkg::req_word_type       req_word,
   output logic                              rsp_valid,
   output stt_pkg::rsp_word_type             rsp_word,
   input  wire                               psel,
   input  wire                               penable,
   input  wire                               pwrite,
   input  wire  [stt_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   import stt_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic [9:0]        tick_period_ff;
   logic              csr_write;
   logic              csr_hit;
   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic [SLOT_W-1:0] slot;

   // tick period register
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1] == CSR_TICK_PERIOD);
   assign csr_write = psel & penable & pwrite & pready & csr_hit;
   assign prdata    = csr_hit ? 32'(tick_period_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= TICK_PERIOD_RESET;
      end else if (csr_write) begin
         tick_period_ff <= pwdata[9:0];
      end
   end

   // sequencer
   stt_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd),
      .slot   (slot)
   );

   // storage and arithmetic
   stt_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .slot        (slot),
      .req_word    (req_word),
      .tick_period (tick_period_ff),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// self-checking bench for the sleep timer table: tracker class, drivers and stimulus
`timescale 1ns / 1ps

module testbench;
   import stt_pkg::*;

   localparam int TABLE_SLOTS = 8;
   // cycles to let the block settle after the last awaited word
   localparam int SETTLE_CYCLES = 4 * TABLE_SLOTS + 64;
   localparam int PHASE_WORDS = 22;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_word_type req_word;
   logic rsp_valid;
   rsp_word_type rsp_word;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   // tracks the timer table and holds the words the block still owes
   class sleep_table_tracker;
      logic [9:0]   tick_period;
      bit           slot_used [TABLE_SLOTS];
      logic [7:0]   slot_owner [TABLE_SLOTS];
      logic [31:0]  slot_target [TABLE_SLOTS];
      logic [31:0]  slot_elapsed [TABLE_SLOTS];
      rsp_word_type awaited [$];
      int           errors;

      function new();
         tick_period = TICK_PERIOD_RESET;
         errors = 0;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_owner[i] = '0;
            slot_target[i] = '0;
            slot_elapsed[i] = '0;
         end
      endfunction

      function rsp_word_type form_word(logic [2:0] kind, logic [7:0] id,
                                       logic [31:0] rem_ms, bit fin);
         rsp_word_type w;
         logic [31:0] whole;
         logic [31:0] frac;
         whole = rem_ms / 32'd1000;
         frac = rem_ms % 32'd1000;
         w.result_kind = kind;
         w.result_task = id;
         w.remaining_ms = rem_ms;
         w.remaining_sec = whole[22:0];
         w.remaining_nsec = 30'(frac * 32'd1000000);
         w.last = fin;
         return w;
      endfunction

      // work out what one accepted word makes the block report
      function void note_request(req_word_type w);
         logic [63:0] us_count;
         logic [63:0] ms_total;
         logic [32:0] sum;
         int slot;
         int due_idx [TABLE_SLOTS];
         int n_due;
         slot = -1;
         n_due = 0;
         case (w.opcode)
            OP_ADD: begin
               if (w.sleep_seconds == 0 && w.sleep_nanoseconds == 0) begin
                  awaited.push_back(form_word(KIND_ZERO, w.task_id, '0, 1'b1));
               end else begin
                  // nanoseconds rounded up to us, then up to ms
                  us_count = (64'(w.sleep_nanoseconds) + 64'd999) / 64'd1000;
                  ms_total = 64'(w.sleep_seconds) * 64'd1000
                           + (us_count + 64'd999) / 64'd1000;
                  if (ms_total > 64'hFFFF_FFFF) ms_total = 64'hFFFF_FFFF;
                  for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                     if (!slot_used[i]) slot = i;
                  if (slot >= 0) begin
                     slot_used[slot] = 1'b1;
                     slot_owner[slot] = w.task_id;
                     slot_target[slot] = ms_total[31:0];
                     slot_elapsed[slot] = '0;
                     awaited.push_back(form_word(KIND_ADDED, w.task_id, '0, 1'b1));
                  end else begin
                     awaited.push_back(form_word(KIND_FULL, w.task_id, '0, 1'b1));
                  end
               end
            end
            OP_REMOVE: begin
               for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                  if (slot_used[i] && slot_owner[i] == w.task_id) slot = i;
               if (slot >= 0) begin
                  slot_used[slot] = 1'b0;
                  awaited.push_back(form_word(KIND_REMOVED, w.task_id,
                     (slot_target[slot] > slot_elapsed[slot])
                        ? slot_target[slot] - slot_elapsed[slot] : 32'd0, 1'b1));
               end else begin
                  awaited.push_back(form_word(KIND_NOTFOUND, w.task_id, '0, 1'b1));
               end
            end
            OP_TICK: begin
               // every used slot advances, wakes capped per tick
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (slot_used[i]) begin
                     sum = {1'b0, slot_elapsed[i]} + 33'(tick_period);
                     slot_elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                     if (slot_elapsed[i] >= slot_target[i] && n_due < MAX_RESULTS) begin
                        due_idx[n_due] = i;
                        n_due++;
                     end
                  end
               end
               for (int k = 0; k < n_due; k++)
                  awaited.push_back(form_word(KIND_WAKE, slot_owner[due_idx[k]], '0,
                                              k == n_due - 1));
            end
            default: ;
         endcase
      endfunction

      // compare one strobed word with the oldest awaited one
      function void check_response(rsp_word_type got);
         rsp_word_type exp_word;
         if (awaited.size() == 0) begin
            $error("unexpected word: kind %0d task %0d", got.result_kind, got.result_task);
            errors++;
            return;
         end
         exp_word = awaited.pop_front();
         if (got.result_kind !== exp_word.result_kind) begin
            $error("result_kind: expected %0d, actual %0d",
                   exp_word.result_kind, got.result_kind);
            errors++;
         end
         if (got.result_task !== exp_word.result_task) begin
            $error("result_task: expected %0d, actual %0d",
                   exp_word.result_task, got.result_task);
            errors++;
         end
         if (got.remaining_ms !== exp_word.remaining_ms) begin
            $error("remaining_ms: expected %0d, actual %0d",
                   exp_word.remaining_ms, got.remaining_ms);
            errors++;
         end
         if (got.remaining_sec !== exp_word.remaining_sec) begin
            $error("remaining_sec: expected %0d, actual %0d",
                   exp_word.remaining_sec, got.remaining_sec);
            errors++;
         end
         if (got.remaining_nsec !== exp_word.remaining_nsec) begin
            $error("remaining_nsec: expected %0d, actual %0d",
                   exp_word.remaining_nsec, got.remaining_nsec);
            errors++;
         end
         if (got.last !== exp_word.last) begin
            $error("last: expected %0d, actual %0d", exp_word.last, got.last);
            errors++;
         end
      endfunction
   endclass

   sleep_table_tracker tracker;
   bit quiet_run;

   sleep_timer_table #(
      .SLOT_COUNT(TABLE_SLOTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_word(rsp_word),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // watch both channels on the rising edge; results first, then the new word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_response(rsp_word);
         if (start && !busy) tracker.note_request(req_word);
      end
   end

   // one word on the request channel, after a random gap unless quiet_run is set
   task automatic send_word(input logic [1:0] op, input logic [7:0] id,
                            input logic [22:0] sec, input logic [29:0] ns);
      int gap;
      gap = quiet_run ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_word <= '{opcode: op, task_id: id, sleep_seconds: sec, sleep_nanoseconds: ns};
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // hold off until every awaited word is in and the block has settled
   task automatic wait_drained();
      start <= 1'b0;
      while (tracker.awaited.size() != 0 || busy) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write: setup then access cycle
   task automatic write_tick_period(input logic [9:0] period);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(4 * CSR_TICK_PERIOD);
      pwdata <= 32'(period);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tracker.tick_period = period;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // random word, mostly short sleeps and removes of live tasks
   task automatic send_random();
      int pick;
      int live [$];
      logic [1:0] op;
      logic [7:0] id;
      logic [22:0] sec;
      logic [29:0] ns;
      pick = $urandom_range(0, 99);
      op = (pick < 35) ? OP_ADD : (pick < 60) ? OP_REMOVE : (pick < 95) ? OP_TICK : 2'd3;
      id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      if (op == OP_REMOVE && $urandom_range(0, 9) < 7) begin
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (tracker.slot_used[i]) live.push_back(tracker.slot_owner[i]);
         if (live.size() > 0) id = live[$urandom_range(0, live.size() - 1)];
      end
      pick = $urandom_range(0, 99);
      sec = (pick < 70) ? 23'd0 : (pick < 85) ? 23'($urandom_range(1, 3)) : 23'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 50) ns = 30'($urandom_range(0, 99_999_999));
      else if (pick < 70) ns = 30'($urandom_range(0, 999_999_999));
      else if (pick < 85) ns = 30'($urandom_range(0, 999) * 1_000_000);
      else ns = 30'($urandom);
      send_word(op, id, sec, ns);
   endtask

   // overall time limit
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus
   initial begin
      logic [9:0] periods [5];
      tracker = new();
      quiet_run = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero request, miss, rounding, saturation, duplicates, full table
      send_word(OP_ADD, 8'd0, 23'd0, 30'd0);
      send_word(OP_REMOVE, 8'd255, 23'd0, 30'd0);
      send_word(OP_ADD, 8'd1, 23'd0, 30'd1);
      send_word(OP_ADD, 8'd255, 23'h7F_FFFF, 30'h3FFF_FFFF);
      send_word(OP_ADD, 8'd2, 23'd0, 30'd999_999_999);
      send_word(OP_ADD, 8'd2, 23'd0, 30'd1_000_000);
      send_word(OP_TICK, 8'd0, 23'd0, 30'd0);
      send_word(OP_REMOVE, 8'd2, 23'd0, 30'd0);
      send_word(OP_REMOVE, 8'd1, 23'd0, 30'd0);
      quiet_run = 1'b1;
      send_word(OP_ADD, 8'd3, 23'd4_294_967, 30'd295_000_000);
      send_word(OP_ADD, 8'd4, 23'd4_294_967, 30'd296_000_000);
      send_word(OP_ADD, 8'd5, 23'd0, 30'd999_999);
      send_word(OP_ADD, 8'd6, 23'd5, 30'd0);
      send_word(OP_ADD, 8'd7, 23'd0, 30'd1_000);
      send_word(OP_ADD, 8'd8, 23'd0, 30'd1);
      send_word(OP_ADD, 8'd9, 23'd0, 30'd5);
      quiet_run = 1'b0;
      send_word(2'd3, 8'hAA, 23'h55_5555, 30'h2AAA_AAAA);
      send_word(OP_TICK, 8'hFF, 23'h7F_FFFF, 30'h3FFF_FFFF);
      send_word(OP_REMOVE, 8'd255, 23'd0, 30'd0);
      send_word(OP_TICK, 8'd0, 23'd0, 30'd0);
      send_word(OP_REMOVE, 8'd2, 23'd0, 30'd0);
      send_word(OP_TICK, 8'd0, 23'd0, 30'd0);
      wait_drained();

      // random phases over several tick periods, extremes included
      periods[0] = 10'd1000;
      periods[1] = 10'd1;
      periods[2] = 10'd0;
      periods[3] = 10'd1023;
      periods[4] = 10'($urandom_range(1, 1000));
      foreach (periods[p]) begin
         write_tick_period(periods[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 9 == 0) quiet_run = ($urandom_range(0, 2) == 0);
            send_random();
         end
         quiet_run = 1'b0;
         wait_drained();
      end

      if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
